FILE: hw/rtl/shlfr_pkg.sv
package shlfr_pkg;

	// Frame store geometry
	localparam int FRAME_BYTES  = 16;
	localparam int IDX_W        = $clog2(FRAME_BYTES);
	localparam int CNT_W        = $clog2(FRAME_BYTES + 1);
	localparam int LEN_POS      = 4;
	localparam int HEADER_BYTES = 5;
	// Length byte plus header needs one bit more than a byte
	localparam int TOT_W        = 9;

	localparam logic [7:0] FIRST_MARKER_RST  = 8'h55;
	localparam logic [7:0] SECOND_MARKER_RST = 8'hAA;

	// Configuration register indexes
	localparam logic REG_FIRST_MARKER  = 1'b0;
	localparam logic REG_SECOND_MARKER = 1'b1;

	// Input command codes
	localparam logic CMD_BYTE    = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	typedef struct packed {
		logic       cmd;
		logic [7:0] rx_byte;
	} in_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic [5:0] byte_index;
		logic       last;
		logic       overflow;
	} out_t;

endpackage

FILE: hw/rtl/sync_header_length_frame_receiver.sv
// Byte transactions are taken one per cycle while collecting, except that the length
// byte waits while an earlier result still occupies the output register.
// An overflow result is loaded into the output register at the edge that accepts the length byte.
// Once its final byte is accepted, a complete frame emits its L+5 bytes, each by a
// frame store read and then an output register load that waits while an earlier
// byte still occupies the register; input stays stalled until the last byte is loaded.
// Reset clears the byte count, held flag, output valid and state; the markers return
// to 0x55 and 0xAA. The frame store is not cleared and needs no clearing pass.
module sync_header_length_frame_receiver
	import shlfr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_t        in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output out_t       out_data,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE     = 3'b001,
		S_EMIT_RD  = 3'b010,
		S_EMIT_OUT = 3'b100
	} state_t;

	state_t           state_q, state_d;
	logic [7:0]       first_marker_q, second_marker_q;
	logic [CNT_W-1:0] byte_count_q, byte_count_d;
	logic             frame_held_q, frame_held_d;
	logic [7:0]       len_q, len_d;
	logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
	logic             out_valid_q;
	out_t             out_q;

	logic             in_fire;
	logic             wr_en;
	logic             rd_en;
	logic [7:0]       rd_data;
	logic             ovf_load;
	logic             emit_load;
	logic             out_free;
	logic [CNT_W-1:0] cnt_inc;
	logic [TOT_W-1:0] total_now;
	logic [TOT_W-1:0] total_held;
	logic             last_w;

	// Frame store
	shlfr_ram #(
		.WIDTH(8),
		.DEPTH(FRAME_BYTES)
	) u_store (
		.clk  (clk),
		.we   (wr_en),
		.waddr(byte_count_q[IDX_W-1:0]),
		.wdata(in_data.rx_byte),
		.re   (rd_en),
		.raddr(rd_idx_q),
		.rdata(rd_data)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_marker_q  <= FIRST_MARKER_RST;
			second_marker_q <= SECOND_MARKER_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FIRST_MARKER:  first_marker_q  <= cfg_data;
				REG_SECOND_MARKER: second_marker_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stall input during emission, and when an overflow result could find the output slot taken
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE) &&
		(out_free || (byte_count_q != CNT_W'(LEN_POS)));
	assign in_fire  = in_valid && in_ready;

	assign cnt_inc    = byte_count_q + CNT_W'(1);
	assign total_now  = ((byte_count_q == CNT_W'(LEN_POS)) ?
		TOT_W'(in_data.rx_byte) : TOT_W'(len_q)) + TOT_W'(HEADER_BYTES);
	assign total_held = TOT_W'(len_q) + TOT_W'(HEADER_BYTES);
	assign last_w     = (TOT_W'(rd_idx_q) + TOT_W'(1)) == total_held;

	assign rd_en     = (state_q == S_EMIT_RD);
	assign emit_load = (state_q == S_EMIT_OUT) && out_free;

	// Collect bytes, handle release, check length, start and step emission
	always_comb begin
		state_d      = state_q;
		byte_count_d = byte_count_q;
		frame_held_d = frame_held_q;
		len_d        = len_q;
		rd_idx_d     = rd_idx_q;
		wr_en        = 1'b0;
		ovf_load     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					if (in_data.cmd == CMD_RELEASE) begin
						frame_held_d = 1'b0;
					end else if (frame_held_q) begin
						byte_count_d = '0;
					end else if (byte_count_q == '0) begin
						if (in_data.rx_byte == first_marker_q) begin
							wr_en        = 1'b1;
							byte_count_d = CNT_W'(1);
						end
					end else if (byte_count_q == CNT_W'(1)) begin
						if (in_data.rx_byte == second_marker_q) begin
							wr_en        = 1'b1;
							byte_count_d = CNT_W'(2);
						end
					end else if (byte_count_q >= CNT_W'(FRAME_BYTES)) begin
						byte_count_d = '0;
					end else begin
						wr_en        = 1'b1;
						byte_count_d = cnt_inc;
						if (byte_count_q == CNT_W'(LEN_POS)) begin
							len_d = in_data.rx_byte;
						end
						if (cnt_inc >= CNT_W'(HEADER_BYTES)) begin
							if (total_now > TOT_W'(FRAME_BYTES)) begin
								byte_count_d = '0;
								ovf_load     = 1'b1;
							end else if (TOT_W'(cnt_inc) == total_now) begin
								byte_count_d = '0;
								frame_held_d = 1'b1;
								rd_idx_d     = '0;
								state_d      = S_EMIT_RD;
							end
						end
					end
				end
			end
			S_EMIT_RD: begin
				state_d = S_EMIT_OUT;
			end
			S_EMIT_OUT: begin
				if (emit_load) begin
					if (last_w) begin
						state_d = S_IDLE;
					end else begin
						rd_idx_d = rd_idx_q + IDX_W'(1);
						state_d  = S_EMIT_RD;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			byte_count_q <= '0;
			frame_held_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			byte_count_q <= byte_count_d;
			frame_held_q <= frame_held_d;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		len_q    <= len_d;
		rd_idx_q <= rd_idx_d;
	end

	// Output register: load a frame byte or an overflow result, drop on take
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ovf_load || emit_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ovf_load) begin
			out_q.frame_byte <= '0;
			out_q.byte_index <= '0;
			out_q.last       <= 1'b1;
			out_q.overflow   <= 1'b1;
		end else if (emit_load) begin
			out_q.frame_byte <= rd_data;
			out_q.byte_index <= 6'(rd_idx_q);
			out_q.last       <= last_w;
			out_q.overflow   <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Emission runs only on a held frame with a cleared count
	a_emit_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (frame_held_q && (byte_count_q == '0) && !in_ready))
		else $error("emission without held frame");

	// A store read is always followed by the output load step
	a_rd_then_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT_RD) |=> (state_q == S_EMIT_OUT))
		else $error("store read not followed by output step");

	// The final frame byte returns the block to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_load && last_w) |=> (state_q == S_IDLE && out_valid_q && out_q.last))
		else $error("final frame byte did not end emission");

	// Overflow returns to hunting without holding
	a_ovf_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_load |=> ((byte_count_q == '0) && !frame_held_q && out_q.overflow))
		else $error("overflow did not return to hunting");

endmodule

FILE: hw/rtl/shlfr_ram.sv
module shlfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read, hold data when not reading
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: sim/sync_header_length_frame_receiver_test.sv
module sync_header_length_frame_receiver_test;
	import shlfr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT     = 200000;
	localparam int SETTLE_CYCLES   = 40;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int MAX_WAIT        = 14;

	// How a directed row gets its expectation
	typedef enum logic [1:0] {
		FROM_MODEL,
		NO_RESULT,
		OVERFLOW_RESULT
	} exp_kind_e;

	typedef struct {
		in_t       item;
		exp_kind_e kind;
	} dir_row_t;

	localparam out_t OVERFLOW_OUT = '{frame_byte: 8'h00, byte_index: 6'd0,
		last: 1'b1, overflow: 1'b1};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	in_t        in_data = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	out_t       out_data;
	logic       cfg_we = 1'b0;
	logic       cfg_index = REG_FIRST_MARKER;
	logic [7:0] cfg_data = 8'h00;

	// Receiver model state
	logic [7:0] mark_first;
	logic [7:0] mark_second;
	int         rx_gathered;
	bit         rx_held;
	logic [7:0] rx_store [FRAME_BYTES];

	out_t frame_expect [$];
	out_t step_results [$];

	int  err_count = 0;
	int  cycle_count = 0;
	int  inputs_taken = 0;
	int  results_taken = 0;
	int  frames_built = 0;
	bit  sender_calm = 1'b0;
	bit  receiver_calm = 1'b0;
	bit  hold_request = 1'b0;

	// Directed stimulus with reset markers 0x55 / 0xAA
	dir_row_t directed_rows [21] = '{
		'{'{cmd: CMD_RELEASE, rx_byte: 8'h00}, NO_RESULT},
		'{'{cmd: CMD_BYTE, rx_byte: 8'h00}, NO_RESULT},
		'{'{cmd: CMD_BYTE, rx_byte: 8'h55}, NO_RESULT},
		'{'{cmd: CMD_BYTE, rx_byte: 8'h00}, NO_RESULT},
		'{'{cmd: CMD_BYTE, rx_byte: 8'hAA}, NO_RESULT},
		'{'{cmd: CMD_BYTE, rx_byte: 8'hFF}, NO_RESULT},
		'{'{cmd: CMD_BYTE, rx_byte: 8'h00}, NO_RESULT},
		'{'{cmd: CMD_BYTE, rx_byte: 8'h00}, FROM_MODEL},
		'{'{cmd: CMD_BYTE, rx_byte: 8'h55}, NO_RESULT},
		'{'{cmd: CMD_RELEASE, rx_byte: 8'hFF}, NO_RESULT},
		'{'{cmd: CMD_RELEASE, rx_byte: 8'h5A}, NO_RESULT},
		'{'{cmd: CMD_BYTE, rx_byte: 8'h55}, NO_RESULT},
		'{'{cmd: CMD_BYTE, rx_byte: 8'hAA}, NO_RESULT},
		'{'{cmd: CMD_BYTE, rx_byte: 8'h12}, NO_RESULT},
		'{'{cmd: CMD_BYTE, rx_byte: 8'h34}, NO_RESULT},
		'{'{cmd: CMD_BYTE, rx_byte: 8'hFF}, OVERFLOW_RESULT},
		'{'{cmd: CMD_BYTE, rx_byte: 8'h55}, NO_RESULT},
		'{'{cmd: CMD_BYTE, rx_byte: 8'hAA}, NO_RESULT},
		'{'{cmd: CMD_BYTE, rx_byte: 8'h00}, NO_RESULT},
		'{'{cmd: CMD_BYTE, rx_byte: 8'h80}, NO_RESULT},
		'{'{cmd: CMD_BYTE, rx_byte: 8'h0C}, OVERFLOW_RESULT}
	};

	sync_header_length_frame_receiver dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				frame_expect.size());
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic log_mismatch(string what);
		err_count++;
		$display("%0t: mismatch: %s", $realtime, what);
	endtask

	function automatic int draw_wait(bit calm);
		if (calm)
			return 0;
		return $urandom_range(0, MAX_WAIT);
	endfunction

	// Advance the receiver model by one transaction, leaving its results in step_results
	task automatic advance_receiver(in_t item);
		int total;
		step_results.delete();
		if (item.cmd == CMD_RELEASE) begin
			rx_held = 1'b0;
			return;
		end
		if (rx_held) begin
			rx_gathered = 0;
			return;
		end
		if (rx_gathered == 0) begin
			if (item.rx_byte == mark_first) begin
				rx_store[0] = item.rx_byte;
				rx_gathered = 1;
			end
			return;
		end
		if (rx_gathered == 1) begin
			if (item.rx_byte == mark_second) begin
				rx_store[1] = item.rx_byte;
				rx_gathered = 2;
			end
			return;
		end
		rx_store[rx_gathered] = item.rx_byte;
		rx_gathered++;
		if (rx_gathered < HEADER_BYTES)
			return;
		total = int'(rx_store[LEN_POS]) + HEADER_BYTES;
		// Declared length does not fit the store
		if (total > FRAME_BYTES) begin
			rx_gathered = 0;
			step_results.push_back(OVERFLOW_OUT);
			return;
		end
		if (rx_gathered != total)
			return;
		for (int i = 0; i < total; i++) begin
			step_results.push_back('{frame_byte: rx_store[i], byte_index: 6'(i),
				last: (i == total - 1), overflow: 1'b0});
		end
		rx_gathered = 0;
		rx_held = 1'b1;
	endtask

	// Offer one transaction, wait for acceptance, then record what it should produce
	task automatic send_item(in_t item, exp_kind_e kind);
		int gap;
		gap = draw_wait(sender_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (!in_ready);
		inputs_taken++;
		advance_receiver(item);
		case (kind)
			FROM_MODEL: begin
				foreach (step_results[i]) frame_expect.push_back(step_results[i]);
			end
			OVERFLOW_RESULT: begin
				frame_expect.push_back(OVERFLOW_OUT);
			end
			default: begin
			end
		endcase
	endtask

	task automatic send_byte(logic [7:0] value);
		send_item('{cmd: CMD_BYTE, rx_byte: value}, FROM_MODEL);
	endtask

	// Release carries a random don't-care byte
	task automatic send_release();
		send_item('{cmd: CMD_RELEASE, rx_byte: 8'($urandom_range(0, 255))}, FROM_MODEL);
	endtask

	// Hold the input idle until every expected result is out, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		while (frame_expect.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic index, logic [7:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (index == REG_FIRST_MARKER)
			mark_first = value;
		else
			mark_second = value;
	endtask

	// Mostly well-formed frames with random content, the rest noise and releases
	task automatic run_frames(int budget);
		int sent;
		int len;
		int pick;
		int extra;
		sent = 0;
		while (sent < budget) begin
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				frames_built++;
				send_byte(mark_first);
				if ($urandom_range(0, 3) == 0) begin
					extra = $urandom_range(1, 2);
					repeat (extra) send_byte(8'($urandom_range(0, 255)));
					sent += extra;
				end
				send_byte(mark_second);
				repeat (2) send_byte(8'($urandom_range(0, 255)));
				pick = $urandom_range(0, 9);
				if (pick < 7)
					len = $urandom_range(0, FRAME_BYTES - HEADER_BYTES);
				else if (pick < 9)
					len = $urandom_range(FRAME_BYTES - HEADER_BYTES + 1, 255);
				else
					len = FRAME_BYTES - HEADER_BYTES;
				send_byte(8'(len));
				sent += 5;
				if (len <= FRAME_BYTES - HEADER_BYTES) begin
					repeat (len) send_byte(8'($urandom_range(0, 255)));
					// Drop a byte while the frame is held
					if ($urandom_range(0, 2) == 0) begin
						send_byte(8'($urandom_range(0, 255)));
						sent++;
					end
					send_release();
					sent += len + 1;
				end
			end else if (pick == 7) begin
				send_release();
				sent++;
			end else begin
				extra = $urandom_range(1, 4);
				repeat (extra) send_byte(8'($urandom_range(0, 255)));
				sent += extra;
			end
		end
	endtask

	// Result side: random stalls, a long hold-off on request, and the field check
	initial begin
		out_t want;
		int   stall;
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else begin
				stall = draw_wait(receiver_calm);
				if (stall > 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			results_taken++;
			if (frame_expect.size() == 0) begin
				log_mismatch($sformatf("unexpected result %p", out_data));
			end else begin
				want = frame_expect.pop_front();
				if (out_data.frame_byte !== want.frame_byte)
					log_mismatch($sformatf("frame_byte %h, want %h", out_data.frame_byte,
						want.frame_byte));
				if (out_data.byte_index !== want.byte_index)
					log_mismatch($sformatf("byte_index %0d, want %0d", out_data.byte_index,
						want.byte_index));
				if (out_data.last !== want.last)
					log_mismatch($sformatf("last %b, want %b", out_data.last, want.last));
				if (out_data.overflow !== want.overflow)
					log_mismatch($sformatf("overflow %b, want %b", out_data.overflow,
						want.overflow));
			end
		end
	end

	// Main sequence
	initial begin
		mark_first  = FIRST_MARKER_RST;
		mark_second = SECOND_MARKER_RST;
		rx_gathered = 0;
		rx_held     = 1'b0;
		foreach (rx_store[i]) rx_store[i] = 8'h00;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) send_item(directed_rows[i].item, directed_rows[i].kind);
		drain();

		// Lowest first marker, highest second marker
		write_reg(REG_FIRST_MARKER, 8'h00);
		write_reg(REG_SECOND_MARKER, 8'hFF);
		run_frames(20);
		drain();

		// Reversed extremes; receiver holds off while the sender runs flat out
		write_reg(REG_FIRST_MARKER, 8'hFF);
		write_reg(REG_SECOND_MARKER, 8'h00);
		sender_calm  = 1'b1;
		hold_request = 1'b1;
		run_frames(20);
		drain();

		// Both markers equal, receiver never stalls
		write_reg(REG_FIRST_MARKER, 8'h7E);
		write_reg(REG_SECOND_MARKER, 8'h7E);
		sender_calm   = 1'b0;
		receiver_calm = 1'b1;
		run_frames(20);
		drain();

		// Random markers with idling on both sides
		write_reg(REG_FIRST_MARKER, 8'($urandom_range(0, 255)));
		write_reg(REG_SECOND_MARKER, 8'($urandom_range(0, 255)));
		receiver_calm = 1'b0;
		run_frames(20);
		drain();

		$display("covered %0d input and %0d result transactions, %0d framed sequences",
			inputs_taken, results_taken, frames_built);
		$display("over five marker settings, with a long output hold-off and input bursts");
		if (err_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/shlfr_pkg.sv
hw/rtl/shlfr_ram.sv
hw/rtl/sync_header_length_frame_receiver.sv
sim/sync_header_length_frame_receiver_test.sv
